// File: hw/rtl/lrutb_pkg.sv
// Shared types and constants of the LRU tagged buffer table.
package lrutb_pkg;

  localparam int unsigned TAG_W     = 32;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CNT_W     = 7;

  localparam logic [TAG_W-1:0]   TAG_NONE    = 32'hFFFF_FFFF;
  localparam logic [STAMP_W-1:0] CLOCK_LIMIT = 32'hFFFF_FFFE;

  typedef enum logic [FUNC_W-1:0] {
    FN_FIND    = 2'd0,
    FN_ALLOC   = 2'd1,
    FN_VICTIM  = 2'd2,
    FN_DISCARD = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_COUNT = 1'b0,
    CFG_DATA_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DISC,
    S_SK_RD,
    S_SK_LD,
    S_SHIFT,
    S_SK_WR,
    S_RENUM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [SLOT_W-1:0]  slot;
  } meta_t;

endpackage

// File: hw/rtl/lrutb_if.sv
// Request and response channel interfaces of the LRU tagged buffer table.
interface lrutb_req_if;
  logic                        valid;
  logic                        ready;
  logic [lrutb_pkg::FUNC_W-1:0] func;
  logic                        area;
  logic [lrutb_pkg::TAG_W-1:0]  tag;

  modport source (output valid, func, area, tag, input ready);
  modport sink   (input valid, func, area, tag, output ready);
endinterface

interface lrutb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [lrutb_pkg::SLOT_W-1:0] slot;
  logic                         old_valid;
  logic [lrutb_pkg::TAG_W-1:0]  old_tag;

  modport source (output valid, ok, slot, old_valid, old_tag, input ready);
  modport sink   (input valid, ok, slot, old_valid, old_tag, output ready);
endinterface

// File: hw/rtl/lru_tagged_buffer_table_core.sv
// Top level of the LRU tagged buffer table: sequencer, clocks and directory memories.
//
// The block keeps two directories (link area and data area) of tag, last-use
// time and buffer slot. Each request item on req_i carries an operation (find,
// allocate, victim, discard all), an area and a tag; each one yields exactly one
// response item on rsp_o with ok, slot, old_valid and old_tag. Both channels
// use a valid/ready handshake. The user must set the entry counts of the two
// areas via the cfg write port only while idle; the block does not enforce it.
//
// All entries live in two synchronous memories (tags, and time plus slot) with
// one read port and one write port each. An operation walks the entries of its
// area one per cycle, as each memory has a single read port. When an area's
// clock reaches its limit, a find or allocate first sorts the area by insertion
// sort through the memory, if it holds more than one entry, and then renumbers
// the times in one more pass.
//
// Reset clears the counts to their defaults, the clocks to zero and the written
// flags of the memories, so every entry reads as its reset value at once.
// The finished response sits in an output register; a new request item is
// taken while it waits, but the next response is held until rsp_o is free.
module lru_tagged_buffer_table_core #(
  parameter int unsigned LINK_ENTRIES = 16,
  parameter int unsigned DATA_ENTRIES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lrutb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lrutb_pkg::CFG_W-1:0]     cfg_wdata_i,
  lrutb_req_if.sink                      req_i,
  lrutb_rsp_if.source                    rsp_o
);

  import lrutb_pkg::*;

  localparam int unsigned ENT_MAX = (LINK_ENTRIES > DATA_ENTRIES) ? LINK_ENTRIES : DATA_ENTRIES;
  localparam int unsigned IW      = $clog2(ENT_MAX);
  localparam int unsigned CW      = IW + 1;
  localparam int unsigned AW      = IW + 1;
  localparam int unsigned MW      = STAMP_W + SLOT_W;

  // Configuration registers.
  logic [4:0] link_cnt_q;
  logic [5:0] data_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_cnt_q <= 5'd16;
      data_cnt_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LINK_COUNT: link_cnt_q <= cfg_wdata_i[4:0];
        CFG_DATA_COUNT: data_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective entry count of the requested area, saturated to its capacity.
  logic [CNT_W-1:0] cnt_raw;
  logic [CNT_W-1:0] cnt_cap;
  logic [CNT_W-1:0] cnt_sat;

  always_comb begin
    cnt_raw = req_i.area ? CNT_W'(data_cnt_q) : CNT_W'(link_cnt_q);
    cnt_cap = req_i.area ? CNT_W'(DATA_ENTRIES) : CNT_W'(LINK_ENTRIES);
    cnt_sat = (cnt_raw > cnt_cap) ? cnt_cap : cnt_raw;
  end

  // Sequencer state.
  state_e             state_q, state_d;
  func_e              func_q, func_d;
  logic               area_q, area_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [CW-1:0]      n_q, n_d;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic               p_q, p_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic [TAG_W-1:0]   key_tag_q, key_tag_d;
  meta_t              key_meta_q, key_meta_d;
  logic [STAMP_W-1:0] best_q, best_d;
  logic [IW-1:0]      pick_q, pick_d;
  logic [SLOT_W-1:0]  pick_slot_q, pick_slot_d;
  logic [TAG_W-1:0]   pick_tag_q, pick_tag_d;
  logic               found_q, found_d;
  logic [STAMP_W-1:0] aclk_q [2];
  logic [STAMP_W-1:0] aclk_d [2];

  // Pending result and output register.
  logic              res_ok_q, res_ok_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              res_ov_q, res_ov_d;
  logic [TAG_W-1:0]  res_ot_q, res_ot_d;
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_ov_q, out_ov_d;
  logic [TAG_W-1:0]  out_ot_q, out_ot_d;

  // Memory ports.
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    wr_idx;
  logic [IW-1:0]    ra_q;
  logic             tag_we, meta_we;
  logic [TAG_W-1:0] tag_wdata;
  meta_t            meta_wdata;
  logic [TAG_W-1:0] tag_rdata;
  logic [MW-1:0]    meta_rdata;
  logic             tag_rvalid, meta_rvalid;
  logic [TAG_W-1:0] tag_rd;
  meta_t            meta_rd;

  lrutb_ram #(.DW(TAG_W), .AW(AW)) u_tag_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (tag_we),
    .waddr_i  ({area_q, wr_idx}),
    .wdata_i  (tag_wdata),
    .raddr_i  ({area_q, rd_idx}),
    .rdata_o  (tag_rdata),
    .rvalid_o (tag_rvalid)
  );

  lrutb_ram #(.DW(MW), .AW(AW)) u_meta_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (meta_we),
    .waddr_i  ({area_q, wr_idx}),
    .wdata_i  (meta_wdata),
    .raddr_i  ({area_q, rd_idx}),
    .rdata_o  (meta_rdata),
    .rvalid_o (meta_rvalid)
  );

  // Entries never written read as their reset values: invalid tag, time zero
  // and the slot equal to the entry's position.
  always_comb begin
    tag_rd = tag_rvalid ? tag_rdata : TAG_NONE;
    if (meta_rvalid) begin
      meta_rd = meta_t'(meta_rdata);
    end else begin
      meta_rd.stamp = '0;
      meta_rd.slot  = SLOT_W'(ra_q);
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q <= rd_idx;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    area_d      = area_q;
    tag_d       = tag_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    p_d         = p_q;
    pidx_d      = pidx_q;
    key_tag_d   = key_tag_q;
    key_meta_d  = key_meta_q;
    best_d      = best_q;
    pick_d      = pick_q;
    pick_slot_d = pick_slot_q;
    pick_tag_d  = pick_tag_q;
    found_d     = found_q;
    aclk_d      = aclk_q;
    res_ok_d    = res_ok_q;
    res_slot_d  = res_slot_q;
    res_ov_d    = res_ov_q;
    res_ot_d    = res_ot_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_ok_d    = out_ok_q;
    out_slot_d  = out_slot_q;
    out_ov_d    = out_ov_q;
    out_ot_d    = out_ot_q;
    rd_idx      = '0;
    wr_idx      = '0;
    tag_we      = 1'b0;
    meta_we     = 1'b0;
    tag_wdata   = tag_q;
    meta_wdata  = key_meta_q;
    req_i.ready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d     = func_e'(req_i.func);
          area_d     = req_i.area;
          tag_d      = req_i.tag;
          n_d        = cnt_sat[CW-1:0];
          i_d        = '0;
          p_d        = 1'b0;
          found_d    = 1'b0;
          best_d     = '1;
          res_ok_d   = 1'b0;
          res_slot_d = '0;
          res_ov_d   = 1'b0;
          res_ot_d   = '0;
          case (func_e'(req_i.func))
            FN_FIND, FN_ALLOC: begin
              if (aclk_q[req_i.area] >= CLOCK_LIMIT) begin
                if (cnt_sat > CNT_W'(1)) begin
                  i_d     = CW'(1);
                  state_d = S_SK_RD;
                end else begin
                  state_d = S_RENUM;
                end
              end else begin
                state_d = S_SCAN;
              end
            end
            FN_VICTIM:  state_d = S_SCAN;
            FN_DISCARD: state_d = S_DISC;
            default:    state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin : scan
        logic hit;
        hit = 1'b0;
        if (p_q) begin
          case (func_q)
            FN_FIND:   hit = (tag_rd == tag_q);
            FN_ALLOC:  hit = (tag_rd == TAG_NONE);
            FN_VICTIM: begin
              hit = (tag_rd == TAG_NONE);
              if (!hit && meta_rd.stamp < best_q) begin
                best_d      = meta_rd.stamp;
                pick_d      = pidx_q;
                pick_slot_d = meta_rd.slot;
                pick_tag_d  = tag_rd;
                found_d     = 1'b1;
              end
            end
            default: hit = 1'b0;
          endcase
        end
        if (hit) begin
          pick_d      = pidx_q;
          pick_slot_d = meta_rd.slot;
          pick_tag_d  = tag_rd;
          found_d     = 1'b1;
          state_d     = S_WRITE;
        end else if (i_q < n_q) begin
          rd_idx = i_q[IW-1:0];
          p_d    = 1'b1;
          pidx_d = i_q[IW-1:0];
          i_d    = CW'(i_q + 1'b1);
        end else begin
          // Scan done: a victim may still have its least-time entry.
          state_d = found_d ? S_WRITE : S_DONE;
        end
      end

      S_WRITE: begin
        wr_idx           = pick_q;
        meta_we          = 1'b1;
        meta_wdata.stamp = aclk_q[area_q];
        meta_wdata.slot  = pick_slot_q;
        tag_we           = (func_q != FN_FIND);
        tag_wdata        = tag_q;
        aclk_d[area_q]   = aclk_q[area_q] + 1'b1;
        res_ok_d         = 1'b1;
        res_slot_d       = pick_slot_q;
        if (func_q == FN_VICTIM) begin
          res_ot_d = pick_tag_q;
          res_ov_d = (pick_tag_q != TAG_NONE);
        end
        state_d = S_DONE;
      end

      S_DISC: begin
        if (i_q < n_q) begin
          wr_idx    = i_q[IW-1:0];
          tag_we    = 1'b1;
          tag_wdata = TAG_NONE;
          i_d       = CW'(i_q + 1'b1);
        end else begin
          aclk_d[area_q] = '0;
          res_ok_d       = 1'b1;
          state_d        = S_DONE;
        end
      end

      // Insertion sort: fetch the key entry, then shift larger entries up.
      S_SK_RD: begin
        rd_idx  = i_q[IW-1:0];
        state_d = S_SK_LD;
      end

      S_SK_LD: begin
        key_tag_d  = tag_rd;
        key_meta_d = meta_rd;
        j_d        = i_q;
        rd_idx     = IW'(i_q - 1'b1);
        state_d    = S_SHIFT;
      end

      S_SHIFT: begin
        if (meta_rd.stamp > key_meta_q.stamp) begin
          wr_idx     = j_q[IW-1:0];
          tag_we     = 1'b1;
          meta_we    = 1'b1;
          tag_wdata  = tag_rd;
          meta_wdata = meta_rd;
          j_d        = CW'(j_q - 1'b1);
          if (j_q > CW'(1)) begin
            rd_idx = IW'(j_q - 2'd2);
          end else begin
            state_d = S_SK_WR;
          end
        end else begin
          wr_idx     = j_q[IW-1:0];
          tag_we     = 1'b1;
          meta_we    = 1'b1;
          tag_wdata  = key_tag_q;
          meta_wdata = key_meta_q;
          i_d        = CW'(i_q + 1'b1);
          if (CW'(i_q + 1'b1) < n_q) begin
            state_d = S_SK_RD;
          end else begin
            i_d     = '0;
            p_d     = 1'b0;
            state_d = S_RENUM;
          end
        end
      end

      S_SK_WR: begin
        wr_idx     = j_q[IW-1:0];
        tag_we     = 1'b1;
        meta_we    = 1'b1;
        tag_wdata  = key_tag_q;
        meta_wdata = key_meta_q;
        i_d        = CW'(i_q + 1'b1);
        if (CW'(i_q + 1'b1) < n_q) begin
          state_d = S_SK_RD;
        end else begin
          i_d     = '0;
          p_d     = 1'b0;
          state_d = S_RENUM;
        end
      end

      // Renumbering pass: times become the positions, the clock the count.
      S_RENUM: begin
        if (p_q) begin
          wr_idx           = pidx_q;
          meta_we          = 1'b1;
          meta_wdata.stamp = STAMP_W'(pidx_q);
          meta_wdata.slot  = meta_rd.slot;
        end
        if (i_q < n_q) begin
          rd_idx = i_q[IW-1:0];
          p_d    = 1'b1;
          pidx_d = i_q[IW-1:0];
          i_d    = CW'(i_q + 1'b1);
        end else begin
          aclk_d[area_q] = STAMP_W'(n_q);
          i_d            = '0;
          p_d            = 1'b0;
          state_d        = S_SCAN;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_slot_d  = res_slot_q;
          out_ov_d    = res_ov_q;
          out_ot_d    = res_ot_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      p_q         <= 1'b0;
      found_q     <= 1'b0;
      aclk_q[0]   <= '0;
      aclk_q[1]   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      p_q         <= p_d;
      found_q     <= found_d;
      aclk_q      <= aclk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    area_q      <= area_d;
    tag_q       <= tag_d;
    n_q         <= n_d;
    i_q         <= i_d;
    j_q         <= j_d;
    pidx_q      <= pidx_d;
    key_tag_q   <= key_tag_d;
    key_meta_q  <= key_meta_d;
    best_q      <= best_d;
    pick_q      <= pick_d;
    pick_slot_q <= pick_slot_d;
    pick_tag_q  <= pick_tag_d;
    res_ok_q    <= res_ok_d;
    res_slot_q  <= res_slot_d;
    res_ov_q    <= res_ov_d;
    res_ot_q    <= res_ot_d;
    out_ok_q    <= out_ok_d;
    out_slot_q  <= out_slot_d;
    out_ov_q    <= out_ov_d;
    out_ot_q    <= out_ot_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.slot      = out_slot_q;
  assign rsp_o.old_valid = out_ov_q;
  assign rsp_o.old_tag   = out_ot_q;

endmodule

// File: hw/rtl/lrutb_ram.sv
// Single-write, single-read synchronous RAM with a per-entry written flag.
module lrutb_ram #(
  parameter int unsigned DW = 32,
  parameter int unsigned AW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  output logic          rvalid_o
);

  localparam int unsigned DEPTH = 2 ** AW;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0]    rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // An entry never written reads as not valid; the user supplies its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule
